>>> rtl/core/stb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stb_pkg: shared types for the software timer bank
// Operation codes, command and result words passed along the cell chain.
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int CNT_W     = 32;
    localparam int IDX_W     = 3;
    localparam int OP_W      = 4;
    localparam int MASK_W    = 8;
    localparam int CELL_ID_W = 6;   // ids up to 63
    localparam int IN_W      = 40;  // 39 bits of fields, padded to bytes
    localparam int OUT_W     = 80;  // 74 bits of fields, padded to bytes

    typedef enum logic [OP_W-1:0] {
        OP_TICK          = 4'd0,
        OP_CREATE        = 4'd1,
        OP_START         = 4'd2,
        OP_STOP          = 4'd3,
        OP_RESET_COUNTER = 4'd4,
        OP_TURN_OFF      = 4'd5,
        OP_DELETE        = 4'd6,
        OP_CHECK         = 4'd7,
        OP_CHANGE        = 4'd8,
        OP_READ          = 4'd9
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] tmo;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0]  counter;
        logic [CNT_W-1:0]  timeout;
        logic              enabled;
        logic              flag;
        logic [MASK_W-1:0] mask;
    } res_t;

    typedef struct packed {
        cmd_t cmd;
        res_t res;
    } token_t;

endpackage
`default_nettype wire

>>> rtl/core/software_timer_bank_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// software_timer_bank_top: bank of software timers
// Command words in, one status word out per command.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one command word: operation, timer index, new timeout.
//    Tick advances every enabled timer; the other operations act on the
//    addressed timer only.
//  - m_axis returns one status word per command: addressed timer counter,
//    timeout, enable, timed-out flag (pre-clear value for check) and the
//    mask of timed-out flags of timers 0..7.
//  - The timers sit in a chain of TIMER_COUNT cells. An accepted word walks
//    the chain one cell per cycle while the chain is not held; each cell
//    updates its own timer and adds its part of the result. One command is
//    in flight at a time: a word passes every cell register and then the
//    output register, and no new word is taken until its result has been
//    loaded into the output register.
//  - The output register frees s_axis_tready for the next word while a
//    status word waits. If m_axis_tready stays low when the next result
//    reaches the chain end, the chain holds until the receiver takes it.
//  - Reset clears all counters, timeouts, enables and flags at once.
// ----------------------------------------------------------------------------
module software_timer_bank_top #(
    parameter int TIMER_COUNT = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [3:0] operation, [6:4] timer_index, [38:7] new_timeout, [39] zero
    input  wire logic [39:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] counter_now, [63:32] timeout_now, [64] enabled_now,
    // [65] timed_out_flag, [73:66] timed_out_mask, [79:74] zero
    output logic [79:0]      m_axis_tdata
);
    import stb_pkg::*;

    token_t                 tok_chain [0:TIMER_COUNT];
    logic [TIMER_COUNT:0]   valid_chain;
    logic                   accept;
    logic                   advance;
    logic                   load_out;
    logic                   busy_reg, busy_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]       m_data_reg;
    res_t                   res_end;

    assign accept = s_axis_tvalid && s_axis_tready;

    // command enters cell 0 straight from the port with an empty result
    assign tok_chain[0] = {s_axis_tdata[3:0], s_axis_tdata[6:4], s_axis_tdata[38:7],
                           {$bits(res_t){1'b0}}};
    assign valid_chain[0] = accept;

    // hold the chain only while a finished word is blocked at its end
    assign advance  = !(valid_chain[TIMER_COUNT] && m_valid_reg && !m_axis_tready);
    assign load_out = valid_chain[TIMER_COUNT] && (!m_valid_reg || m_axis_tready);

    genvar g;
    generate
        for (g = 0; g < TIMER_COUNT; g++)
        begin : g_cell
            stb_cell #(
                .CELL_ID (g)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .in_valid  (valid_chain[g]),
                .in_tok    (tok_chain[g]),
                .out_valid (valid_chain[g+1]),
                .out_tok   (tok_chain[g+1])
            );
        end
    endgenerate

    assign res_end = tok_chain[TIMER_COUNT].res;

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (load_out)
            busy_next = 1'b0;
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (load_out)
            m_valid_next = 1'b1;
        else if (m_axis_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            m_data_reg <= {6'b0, res_end.mask, res_end.flag, res_end.enabled,
                           res_end.timeout, res_end.counter};
    end

    assign s_axis_tready = !busy_reg;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // at most one command word in the chain
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(valid_chain[TIMER_COUNT:1]))
        else $error("more than one command in the cell chain");

    // idle means an empty chain
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (valid_chain[TIMER_COUNT:1] == '0))
        else $error("chain holds a word while idle");

    // an accepted word keeps the block busy until its result is loaded
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("not busy after accepting a word");

    // a result is only loaded for a word that was in flight
    a_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> busy_reg)
        else $error("result loaded with nothing in flight");

endmodule
`default_nettype wire

>>> rtl/core/stb_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stb_cell: one timer of the bank
// Holds one timer, applies the passing command word and hands it on.
// ----------------------------------------------------------------------------
module stb_cell #(
    parameter int CELL_ID = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire logic            in_valid,
    input  wire stb_pkg::token_t in_tok,
    output logic                 out_valid,
    output stb_pkg::token_t      out_tok
);
    import stb_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] tmo_reg, tmo_next;
    logic             en_reg, en_next;
    logic             flag_reg, flag_next;
    logic             valid_reg;
    token_t           tok_reg, tok_next;
    logic             hit;
    logic [CNT_W-1:0] cnt_inc;
    op_t              op;

    assign op      = op_t'(in_tok.cmd.op);
    assign hit     = ({{(CELL_ID_W-IDX_W){1'b0}}, in_tok.cmd.idx} == CELL_ID_W'(CELL_ID));
    assign cnt_inc = cnt_reg + CNT_W'(1);

    always_comb
    begin
        cnt_next  = cnt_reg;
        tmo_next  = tmo_reg;
        en_next   = en_reg;
        flag_next = flag_reg;
        if (op == OP_TICK)
        begin
            if (en_reg)
            begin
                if (cnt_inc == tmo_reg)
                begin
                    cnt_next  = '0;
                    flag_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
        end
        else if (hit)
        begin
            case (op)
                OP_CREATE:
                begin
                    if (tmo_reg == '0)
                    begin
                        tmo_next  = in_tok.cmd.tmo;
                        cnt_next  = '0;
                        en_next   = 1'b0;
                        flag_next = 1'b0;
                    end
                end
                OP_START:
                begin
                    if (tmo_reg != '0)
                        en_next = 1'b1;
                end
                OP_STOP:          en_next = 1'b0;
                OP_RESET_COUNTER: cnt_next = '0;
                OP_TURN_OFF:
                begin
                    cnt_next  = '0;
                    en_next   = 1'b0;
                    flag_next = 1'b0;
                end
                OP_DELETE:
                begin
                    cnt_next  = '0;
                    tmo_next  = '0;
                    en_next   = 1'b0;
                    flag_next = 1'b0;
                end
                OP_CHECK:  flag_next = 1'b0;
                OP_CHANGE: tmo_next = in_tok.cmd.tmo;
                default:   ;
            endcase
        end
    end

    // result accumulator: addressed timer fills the status, low cells fill the mask
    always_comb
    begin
        tok_next = in_tok;
        if (hit)
        begin
            tok_next.res.counter = cnt_next;
            tok_next.res.timeout = tmo_next;
            tok_next.res.enabled = en_next;
            tok_next.res.flag    = (op == OP_CHECK) ? flag_reg : flag_next;
        end
        if (CELL_ID < MASK_W)
            tok_next.res.mask[CELL_ID % MASK_W] = flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            tmo_reg   <= '0;
            en_reg    <= 1'b0;
            flag_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
            if (in_valid)
            begin
                cnt_reg  <= cnt_next;
                tmo_reg  <= tmo_next;
                en_reg   <= en_next;
                flag_reg <= flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
            tok_reg <= tok_next;
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

endmodule
`default_nettype wire

>>> tb/software_timer_bank_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// software_timer_bank_checker: status prediction and compare
// Watches both stream channels of the timer bank. It keeps its own copy of
// the timers, predicts one status word per accepted command word and
// compares each returned status word field by field.
// ----------------------------------------------------------------------------
module software_timer_bank_checker #(
    parameter int TIMER_COUNT = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [79:0] m_axis_tdata,
    output int               mismatch_count,
    output int               status_pending
);

    import stb_pkg::*;

    logic [CNT_W-1:0] timer_counts  [TIMER_COUNT];
    logic [CNT_W-1:0] timer_limits  [TIMER_COUNT];
    logic             timer_running [TIMER_COUNT];
    logic             timer_expired [TIMER_COUNT];

    res_t expected_status_q [$];

    task automatic apply_timer_command(input cmd_t cmd, output res_t status);
        logic in_range;
        logic flag_before;
        int   i;
        begin
            in_range    = int'(cmd.idx) < TIMER_COUNT;
            flag_before = 1'b0;
            if (cmd.op == OP_TICK) begin
                for (i = 0; i < TIMER_COUNT; i++) begin
                    if (timer_running[i]) begin
                        timer_counts[i] = timer_counts[i] + 1'b1;
                        if (timer_counts[i] == timer_limits[i]) begin
                            timer_counts[i]  = '0;
                            timer_expired[i] = 1'b1;
                        end
                    end
                end
            end else if (in_range) begin
                case (cmd.op)
                    OP_CREATE:
                    begin
                        // only a free timer (zero timeout) takes the new timeout
                        if (timer_limits[cmd.idx] == '0) begin
                            timer_limits[cmd.idx]  = cmd.tmo;
                            timer_counts[cmd.idx]  = '0;
                            timer_expired[cmd.idx] = 1'b0;
                            timer_running[cmd.idx] = 1'b0;
                        end
                    end
                    OP_START:
                    begin
                        if (timer_limits[cmd.idx] != '0)
                            timer_running[cmd.idx] = 1'b1;
                    end
                    OP_STOP:
                    begin
                        timer_running[cmd.idx] = 1'b0;
                    end
                    OP_RESET_COUNTER:
                    begin
                        timer_counts[cmd.idx] = '0;
                    end
                    OP_TURN_OFF:
                    begin
                        timer_counts[cmd.idx]  = '0;
                        timer_running[cmd.idx] = 1'b0;
                        timer_expired[cmd.idx] = 1'b0;
                    end
                    OP_DELETE:
                    begin
                        timer_counts[cmd.idx]  = '0;
                        timer_limits[cmd.idx]  = '0;
                        timer_running[cmd.idx] = 1'b0;
                        timer_expired[cmd.idx] = 1'b0;
                    end
                    OP_CHECK:
                    begin
                        flag_before            = timer_expired[cmd.idx];
                        timer_expired[cmd.idx] = 1'b0;
                    end
                    OP_CHANGE:
                    begin
                        timer_limits[cmd.idx] = cmd.tmo;
                    end
                    default:
                    begin
                    end
                endcase
            end

            status = '0;
            if (in_range) begin
                status.counter = timer_counts[cmd.idx];
                status.timeout = timer_limits[cmd.idx];
                status.enabled = timer_running[cmd.idx];
                status.flag    = (cmd.op == OP_CHECK) ? flag_before
                                                      : timer_expired[cmd.idx];
            end
            for (i = 0; i < TIMER_COUNT && i < MASK_W; i++)
                status.mask[i] = timer_expired[i];
        end
    endtask

    function automatic int field_differs(input string field, input logic [CNT_W-1:0] want,
                                         input logic [CNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch_channels
        cmd_t cmd;
        res_t want;
        res_t got;
        int   i;
        if (!rst_n) begin
            for (i = 0; i < TIMER_COUNT; i++) begin
                timer_counts[i]  = '0;
                timer_limits[i]  = '0;
                timer_running[i] = 1'b0;
                timer_expired[i] = 1'b0;
            end
            expected_status_q.delete();
            mismatch_count = 0;
            status_pending = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                cmd.op  = s_axis_tdata[3:0];
                cmd.idx = s_axis_tdata[6:4];
                cmd.tmo = s_axis_tdata[38:7];
                apply_timer_command(cmd, want);
                expected_status_q.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.counter = m_axis_tdata[31:0];
                got.timeout = m_axis_tdata[63:32];
                got.enabled = m_axis_tdata[64];
                got.flag    = m_axis_tdata[65];
                got.mask    = m_axis_tdata[73:66];
                if (expected_status_q.size() == 0) begin
                    $display("%0t: status word with none expected: expected nothing, ",
                             "actual 0x%0h", $time, m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_status_q.pop_front();
                    mismatch_count += field_differs("counter_now", want.counter,
                                                    got.counter);
                    mismatch_count += field_differs("timeout_now", want.timeout,
                                                    got.timeout);
                    mismatch_count += field_differs("enabled_now", CNT_W'(want.enabled),
                                                    CNT_W'(got.enabled));
                    mismatch_count += field_differs("timed_out_flag", CNT_W'(want.flag),
                                                    CNT_W'(got.flag));
                    mismatch_count += field_differs("timed_out_mask", CNT_W'(want.mask),
                                                    CNT_W'(got.mask));
                end
            end
            status_pending = expected_status_q.size();
        end
    end

endmodule
`default_nettype wire

>>> tb/tb_software_timer_bank_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_software_timer_bank_top: testbench for the software timer bank
// Drives command words (directed corner cases, then a long random mix heavy
// on ticks and small timeouts so timers really expire), throttles both
// channels at random and lets the checker predict and compare every status
// word. A stall watchdog bounds the run.
// ----------------------------------------------------------------------------
module tb_software_timer_bank_top;

    import stb_pkg::*;

    localparam int TIMER_COUNT = 8;
    // Longest legal quiet spell is a few chain walks plus a receiver stall.
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_WORDS = 1525;

    // Codes with no operation behind them; the bank reports them as a read.
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 4'd10;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 4'd15;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;

    int mismatch_count;
    int status_pending;
    int quiet_cycles = 0;
    bit no_idle = 1'b0;   // set for a stretch with no sender idle cycles and the receiver always ready

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    software_timer_bank_top #(
        .TIMER_COUNT (TIMER_COUNT)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    software_timer_bank_checker #(
        .TIMER_COUNT (TIMER_COUNT)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .status_pending (status_pending)
    );

    // Receiver back-pressure: ready in about 86 percent of cycles.
    always @(negedge clk)
    begin
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 14);
    end

    // Watchdog: any cycle without a handshake on either side counts.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // One command word. Optional idle cycles first, then valid is held until
    // the bank takes the word. Valid is never dropped and raised in one step.
    task automatic send_command(input logic [OP_W-1:0] op, input int unsigned idx,
                                input logic [CNT_W-1:0] tmo);
        begin
            while (!no_idle && $urandom_range(0, 99) < 14) begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
            end
            @(negedge clk);
            s_axis_tvalid <= 1'b1;
            // bit 39 is padding
            s_axis_tdata  <= {1'b0, tmo, idx[IDX_W-1:0], op};
            do
                @(posedge clk);
            while (!s_axis_tready);
        end
    endtask

    // Hold off the sender until every status word is back.
    task automatic drain_status;
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            while (status_pending != 0)
                @(negedge clk);
        end
    endtask

    // Random command: ticks dominate; timeouts mostly small so timers expire,
    // with zero, full-range and single-bit values mixed in.
    task automatic send_random_command;
        logic [OP_W-1:0]  op;
        logic [CNT_W-1:0] tmo;
        int unsigned      pick;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                op = OP_TICK;
            else if (pick < 95)
                op = OP_W'($urandom_range(OP_CREATE, OP_READ));
            else
                op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));

            pick = $urandom_range(0, 99);
            if (pick < 60)
                tmo = $urandom_range(1, 12);
            else if (pick < 70)
                tmo = '0;
            else if (pick < 85)
                tmo = $urandom;
            else if (pick < 92)
                tmo = '1;
            else
                tmo = 32'd1 << $urandom_range(0, CNT_W - 1);

            send_command(op, $urandom_range(0, 7), tmo);
        end
    endtask

    initial
    begin : stimulus
        int n;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // --- directed corners ---
        send_command(OP_READ,          0, '0);            // state straight after reset
        send_command(OP_CREATE,        0, 32'd2);
        send_command(OP_CREATE,        0, 32'd5);         // already in use: ignored
        send_command(OP_START,         1, '0);            // zero timeout: no start
        send_command(OP_START,         0, '0);
        send_command(OP_TICK,          3, '0);
        send_command(OP_TICK,          0, '0);            // timer 0 expires here
        send_command(OP_CHECK,         0, '0);            // reports flag, then clears
        send_command(OP_CHECK,         0, '0);
        send_command(OP_CREATE,        7, 32'hFFFF_FFFF);
        send_command(OP_START,         7, '0);
        send_command(OP_TICK,          7, '0);
        send_command(OP_STOP,          7, '0);
        send_command(OP_RESET_COUNTER, 7, '0);
        send_command(OP_CHANGE,        0, '0);            // zero timeout while running
        send_command(OP_TICK,          0, '0);
        send_command(OP_TICK,          0, '0);
        send_command(OP_CHANGE,        0, 32'd1);         // timeout now below the count
        send_command(OP_TICK,          0, '0);
        send_command(OP_TURN_OFF,      0, '0);
        send_command(OP_DELETE,        7, '0);
        send_command(OP_UNUSED_LAST,   3, 32'hFFFF_FFFF); // unused code acts as read
        send_command(OP_UNUSED_FIRST,  5, 32'h8000_0000);
        send_command(OP_CHANGE,        5, 32'h8000_0000);
        send_command(OP_DELETE,        5, '0);

        drain_status();

        // --- random mix ---
        for (n = 0; n < RANDOM_WORDS; n++) begin
            no_idle = (n >= 500 && n < 800);
            if (n == 1000)
                drain_status();
            send_random_command();
        end

        // --- wind down ---
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (status_pending != 0)
            @(negedge clk);
        repeat (2 * (TIMER_COUNT + 1)) @(posedge clk);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
